### hw/rtl/armt_pkg.sv
package armt_pkg;

    localparam int ADDR_W = 32;
    localparam int TAG_W  = 8;
    localparam int OIDX_W = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] len;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              hit;
        logic [OIDX_W-1:0] idx;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              full;
    } result_t;

endpackage

### hw/rtl/address_range_map_table.sv
// Channel   Direction  Fields
// s_        in         cmd, addr, range_len, device_tag
// m_        out        hit, entry_index, tag_out, match_start, match_len, table_full
//
// An insert's result is registered in the controller and moves to the output register once that register can take it.
// A lookup reads one stored range per cycle through a single comparator, ending early on the first match.
// Reset is synchronous and active low; it empties the table.
// The input side takes a new transfer while a result still waits in the output register.
module address_range_map_table import armt_pkg::*; #(
    parameter int MAX_RANGES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [ADDR_W-1:0] s_addr,
    input  logic [ADDR_W-1:0] s_range_len,
    input  logic [TAG_W-1:0]  s_device_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [OIDX_W-1:0] m_entry_index,
    output logic [TAG_W-1:0]  m_tag_out,
    output logic [ADDR_W-1:0] m_match_start,
    output logic [ADDR_W-1:0] m_match_len,
    output logic              m_table_full
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             m_valid_reg;
    result_t          out_reg;

    armt_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_addr       (s_addr),
        .s_range_len  (s_range_len),
        .s_device_tag (s_device_tag),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    armt_store #(
        .MAX_RANGES (MAX_RANGES),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = out_reg.hit;
    assign m_entry_index = out_reg.idx;
    assign m_tag_out     = out_reg.tag;
    assign m_match_start = out_reg.start;
    assign m_match_len   = out_reg.len;
    assign m_table_full  = out_reg.full;

endmodule

### hw/rtl/armt_store.sv
module armt_store import armt_pkg::*; #(
    parameter int MAX_RANGES = 16,
    parameter int IDX_W      = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_RANGES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/armt_ctrl.sv
module armt_ctrl import armt_pkg::*; #(
    parameter int MAX_RANGES = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [ADDR_W-1:0] s_addr,
    input  logic [ADDR_W-1:0] s_range_len,
    input  logic [TAG_W-1:0]  s_device_tag,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output entry_t            wr_data,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  entry_t            rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } state_t;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_RANGES);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    result_t           res_reg, res_next;
    logic              match;
    logic [IDX_W+OIDX_W-1:0] cmp_idx_ext;
    logic [IDX_W+OIDX_W-1:0] used_ext;

    assign match       = (rd_data.start <= addr_reg) && (addr_reg <= rd_data.last);
    assign cmp_idx_ext = {{OIDX_W{1'b0}}, cmp_idx_reg};
    assign used_ext    = {{OIDX_W{1'b0}}, used_reg[IDX_W-1:0]};

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        addr_next    = addr_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = used_reg[IDX_W-1:0];
        wr_data      = '{start: s_addr,
                         last:  s_addr + s_range_len - 32'd1,
                         len:   s_range_len,
                         tag:   s_device_tag};
        rd_en        = 1'b0;
        rd_addr      = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_INSERT) begin
                        res_next = '0;
                        if (used_reg == FULL_COUNT) begin
                            res_next.full = 1'b1;
                        end else begin
                            wr_en        = 1'b1;
                            res_next.idx = used_ext[OIDX_W-1:0];
                            used_next    = used_reg + CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end else begin
                        addr_next    = s_addr;
                        rd_idx_next  = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (cmp_vld_reg && match) begin
                    res_next = '{hit:   1'b1,
                                 idx:   cmp_idx_ext[OIDX_W-1:0],
                                 tag:   rd_data.tag,
                                 start: rd_data.start,
                                 len:   rd_data.len,
                                 full:  1'b0};
                    state_next = ST_DONE;
                end else if (rd_idx_reg < used_reg) begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end else if (cmp_vld_reg) begin
                    cmp_vld_next = 1'b0;
                end else begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cmp_vld_reg <= cmp_vld_next;
        end
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        addr_reg    <= addr_next;
        res_reg     <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule
